@@ sv/nest_pkg.sv @@
// Package: shared constants, codes and types of the nearest entry search table.
`timescale 1ns / 1ps
`default_nettype none
package nest_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int COORD_W   = 24;
  localparam int HANDLE_W  = 32;
  localparam int RADIUS_W  = 23;
  localparam int SQ_W      = 2 * RADIUS_W;
  localparam int DIST_W    = SQ_W + 2;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_NEAREST = 2'd1,
    ACT_HANDLE  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    coord_t              x;
    coord_t              y;
    coord_t              z;
  } entry_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic [RADIUS_W-1:0] radius;
  } query_t;

  // read-back of one slot from the store
  typedef struct packed {
    logic              vld;
    logic              ent_valid;
    logic [SLOT_W-1:0] idx;
    entry_t            entry;
  } rd_t;

  // one scored slot leaving the distance pipeline
  typedef struct packed {
    logic              vld;
    logic              ent_valid;
    logic              match;
    logic              in_range;
    logic [SLOT_W-1:0] idx;
    logic [DIST_W-1:0] d2;
  } cand_t;

endpackage
`default_nettype wire

@@ sv/nest_store.sv @@
// Slot store: entry memory with registered read, and per-slot valid bits.
`timescale 1ns / 1ps
`default_nettype none
module nest_store (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [nest_pkg::SLOT_W-1:0] wr_slot,
  input  wire logic                        wr_valid,
  input  wire nest_pkg::entry_t            wr_entry,
  input  wire logic                        rd_en,
  input  wire logic [nest_pkg::SLOT_W-1:0] rd_slot,
  output nest_pkg::rd_t                    rd
);

  nest_pkg::entry_t            mem [nest_pkg::NUM_SLOTS];
  logic [nest_pkg::NUM_SLOTS-1:0] valid_q;

  nest_pkg::entry_t            rd_entry;
  logic                        rd_ent_valid;
  logic [nest_pkg::SLOT_W-1:0] rd_idx;
  logic                        rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_entry;
    end
    rd_entry     <= mem[rd_slot];
    rd_ent_valid <= valid_q[rd_slot];
    rd_idx       <= rd_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_slot] <= wr_valid;
      end
      rd_vld <= rd_en;
    end
  end

  always_comb begin
    rd.vld       = rd_vld;
    rd.ent_valid = rd_ent_valid;
    rd.idx       = rd_idx;
    rd.entry     = rd_entry;
  end

endmodule
`default_nettype wire

@@ sv/nest_dist.sv @@
// Distance pipeline: per-axis differences, squares, then squared-distance sum.
`timescale 1ns / 1ps
`default_nettype none
module nest_dist (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire nest_pkg::query_t q,
  input  wire nest_pkg::rd_t    rd,
  output nest_pkg::cand_t       cand,
  output logic                  busy
);

  localparam int DW = nest_pkg::COORD_W + 1;
  localparam int RW = nest_pkg::RADIUS_W;
  localparam int SW = nest_pkg::SQ_W;
  localparam int LW = nest_pkg::DIST_W;

  logic signed [DW-1:0] diff_x, diff_y, diff_z;
  logic [DW-1:0]        abs_x, abs_y, abs_z;
  logic                 near_x, near_y, near_z;

  // stage 1
  logic                          s1_vld, s1_ent_valid, s1_match, s1_in_range;
  logic [nest_pkg::SLOT_W-1:0]   s1_idx;
  logic [RW-1:0]                 s1_dx, s1_dy, s1_dz;
  // stage 2
  logic                          s2_vld, s2_ent_valid, s2_match, s2_in_range;
  logic [nest_pkg::SLOT_W-1:0]   s2_idx;
  logic [SW-1:0]                 s2_sx, s2_sy, s2_sz;
  // stage 3
  logic                          cand_vld, cand_ent_valid, cand_match, cand_in_range;
  logic [nest_pkg::SLOT_W-1:0]   cand_idx;
  logic [LW-1:0]                 cand_d2;

  always_comb begin
    diff_x = DW'($signed(q.x)) - DW'($signed(rd.entry.x));
    diff_y = DW'($signed(q.y)) - DW'($signed(rd.entry.y));
    diff_z = DW'($signed(q.z)) - DW'($signed(rd.entry.z));
    abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
    abs_z  = diff_z[DW-1] ? DW'(-diff_z) : DW'(diff_z);
    near_x = abs_x < DW'(q.radius);
    near_y = abs_y < DW'(q.radius);
    near_z = abs_z < DW'(q.radius);
  end

  always_ff @(posedge clk) begin
    s1_ent_valid <= rd.ent_valid;
    s1_match     <= rd.entry.handle == q.handle;
    s1_in_range  <= near_x & near_y & near_z;
    s1_idx       <= rd.idx;
    s1_dx        <= abs_x[RW-1:0];
    s1_dy        <= abs_y[RW-1:0];
    s1_dz        <= abs_z[RW-1:0];

    s2_ent_valid <= s1_ent_valid;
    s2_match     <= s1_match;
    s2_in_range  <= s1_in_range;
    s2_idx       <= s1_idx;
    s2_sx        <= s1_dx * s1_dx;
    s2_sy        <= s1_dy * s1_dy;
    s2_sz        <= s1_dz * s1_dz;

    cand_ent_valid <= s2_ent_valid;
    cand_match     <= s2_match;
    cand_in_range  <= s2_in_range;
    cand_idx       <= s2_idx;
    cand_d2        <= LW'(s2_sx) + LW'(s2_sy) + LW'(s2_sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      cand_vld <= 1'b0;
    end else begin
      s1_vld   <= rd.vld;
      s2_vld   <= s1_vld;
      cand_vld <= s2_vld;
    end
  end

  always_comb begin
    cand.vld       = cand_vld;
    cand.ent_valid = cand_ent_valid;
    cand.match     = cand_match;
    cand.in_range  = cand_in_range;
    cand.idx       = cand_idx;
    cand.d2        = cand_d2;
  end

  assign busy = s1_vld | s2_vld | cand_vld;

endmodule
`default_nettype wire

@@ sv/nearest_entry_search_table.sv @@
// Top level: stream ports, scan sequencer, best-candidate tracking and result register.
`timescale 1ns / 1ps
`default_nettype none
// A write transfer fills one slot and returns nothing; while no query is in progress,
// writes can follow each other every cycle. A nearest or handle query walks all
// NUM_SLOTS slots in index order, one entry-memory read per cycle, through a
// four-register read and distance pipeline. Its result is offered after the scan
// has issued all NUM_SLOTS reads, the reads have passed the four pipeline registers,
// the sequencer has seen the pipeline empty and the result register has been loaded.
// The next input transfer can follow once the result register is loaded; no input is
// taken while a query is in progress. The scan uses the single read port of the
// entry memory. Input is taken again while the result still waits on the output; a
// later query then holds in its last cycle until the output register is free. Valid
// bits clear at reset, so the block is usable in the first cycle after reset.
module nearest_entry_search_table (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // slot[5:0], slot_valid[6], handle[38:7], pos_x[62:39], pos_y[86:63],
  // pos_z[110:87], radius[133:111], zero[135:134]
  input  wire logic [135:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // found_slot[5:0], zero[7:6]
  output logic [7:0]        m_axis_tdata,
  // found[0]
  output logic [0:0]        m_axis_tuser
);

  localparam int SW = nest_pkg::SLOT_W;
  localparam int LW = nest_pkg::DIST_W;

  nest_pkg::state_t  state, state_next;
  nest_pkg::action_t in_action;
  nest_pkg::query_t  in_q, q;
  nest_pkg::entry_t  in_entry;
  nest_pkg::rd_t     rd;
  nest_pkg::cand_t   cand;

  logic [SW-1:0] in_slot;
  logic          in_slot_valid;
  logic          accept, wr_en, start, issue, last_issue, load_res, pipe_busy;
  logic          take_nearest, take_handle, take;
  logic          dist_busy;
  logic [nest_pkg::SQ_W-1:0] rad_sq;

  logic          is_nearest;
  logic [SW-1:0] cnt;
  logic [LW-1:0] best;
  logic          best_found;
  logic [SW-1:0] best_idx;
  logic          res_full;
  logic          res_found;
  logic [SW-1:0] res_slot;

  always_comb begin
    in_action       = nest_pkg::action_t'(s_axis_tuser);
    in_slot         = s_axis_tdata[5:0];
    in_slot_valid   = s_axis_tdata[6];
    in_q.handle     = s_axis_tdata[38:7];
    in_q.x          = s_axis_tdata[62:39];
    in_q.y          = s_axis_tdata[86:63];
    in_q.z          = s_axis_tdata[110:87];
    in_q.radius     = s_axis_tdata[133:111];
    in_entry.handle = in_q.handle;
    in_entry.x      = in_q.x;
    in_entry.y      = in_q.y;
    in_entry.z      = in_q.z;
  end

  assign accept     = s_axis_tvalid & s_axis_tready;
  assign last_issue = cnt == SW'(nest_pkg::NUM_SLOTS - 1);
  assign pipe_busy  = rd.vld | dist_busy;
  assign rad_sq     = in_q.radius * in_q.radius;

  always_comb begin
    wr_en = 1'b0;
    start = 1'b0;
    if (accept) begin
      case (in_action)
        nest_pkg::ACT_WRITE:   wr_en = int'(in_slot) < nest_pkg::NUM_SLOTS;
        nest_pkg::ACT_NEAREST: start = 1'b1;
        nest_pkg::ACT_HANDLE:  start = 1'b1;
        default:               start = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nest_pkg::ST_IDLE:  if (start) state_next = nest_pkg::ST_SCAN;
      nest_pkg::ST_SCAN:  if (last_issue) state_next = nest_pkg::ST_DRAIN;
      nest_pkg::ST_DRAIN: if (!pipe_busy) state_next = nest_pkg::ST_DONE;
      nest_pkg::ST_DONE:  if (!res_full || m_axis_tready) state_next = nest_pkg::ST_IDLE;
      default:            state_next = nest_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load_res      = 1'b0;
    case (state)
      nest_pkg::ST_IDLE: s_axis_tready = 1'b1;
      nest_pkg::ST_SCAN: issue = 1'b1;
      nest_pkg::ST_DONE: load_res = !res_full || m_axis_tready;
      default:           issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nest_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  nest_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_slot  (in_slot),
    .wr_valid (in_slot_valid),
    .wr_entry (in_entry),
    .rd_en    (issue),
    .rd_slot  (cnt),
    .rd       (rd)
  );

  nest_dist u_dist (
    .clk  (clk),
    .rst  (rst),
    .q    (q),
    .rd   (rd),
    .cand (cand),
    .busy (dist_busy)
  );

  // strict compare keeps the lowest index on ties; handle search keeps the first hit
  assign take_nearest = is_nearest & cand.in_range & (cand.d2 < best);
  assign take_handle  = !is_nearest & cand.match & !best_found;
  assign take         = cand.vld & cand.ent_valid & (take_nearest | take_handle);

  always_ff @(posedge clk) begin
    if (start) begin
      q          <= in_q;
      is_nearest <= in_action == nest_pkg::ACT_NEAREST;
      best       <= LW'(rad_sq);
      best_idx   <= '0;
      cnt        <= '0;
    end else begin
      if (issue) begin
        cnt <= cnt + SW'(1);
      end
      if (take) begin
        best     <= cand.d2;
        best_idx <= cand.idx;
      end
    end
    if (load_res) begin
      res_found <= best_found;
      res_slot  <= best_found ? best_idx : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      res_full   <= 1'b0;
    end else begin
      if (start) begin
        best_found <= 1'b0;
      end else if (take) begin
        best_found <= 1'b1;
      end
      if (load_res) begin
        res_full <= 1'b1;
      end else if (m_axis_tready) begin
        res_full <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = res_full;
  assign m_axis_tdata  = {2'b00, res_slot};
  assign m_axis_tuser  = res_found;

endmodule
`default_nettype wire
